// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/rrs_pkg.sv -----
// ----------------------------------------------------------------------------
// rrs_pkg
// types, sizes and codes shared by the round robin scheduler modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rrs_pkg;

  // sizing
  localparam int QUEUE_DEPTH = 64;
  localparam int MAX_CPUS    = 4;
  localparam int QA_W        = $clog2(QUEUE_DEPTH);
  localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int CPU_W       = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;
  localparam int CPUN_W      = $clog2(MAX_CPUS + 1);

  // register indexes
  localparam logic [1:0] REG_TIME_SLICE = 2'd0;
  localparam logic [1:0] REG_CPU_COUNT  = 2'd1;

  // reset values of the registers
  localparam logic [15:0] SLICE_RST = 16'd5;
  localparam logic [2:0]  CPUS_RST  = 3'd4;

  // result kinds
  localparam logic [1:0] KIND_ACCEPT = 2'd0;
  localparam logic [1:0] KIND_REJECT = 2'd1;
  localparam logic [1:0] KIND_SLICE  = 2'd2;
  localparam logic [1:0] KIND_IDLE   = 2'd3;

  // input actions
  localparam logic ACT_ADD   = 1'b0;
  localparam logic ACT_ROUND = 1'b1;

  typedef struct packed {
    logic        action;
    logic [15:0] job_id;
    logic [15:0] burst_time;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  cpu_index;
    logic [15:0] run_job;
    logic [31:0] slice_start;
    logic [31:0] slice_end;
    logic        finished;
    logic [31:0] wait_time;
    logic        last;
  } out_item_t;

  // one queued job
  typedef struct packed {
    logic [15:0] id;
    logic [15:0] burst;
    logic [15:0] remain;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REPLY,
    ST_POP,
    ST_LOAD,
    ST_RUN
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic take_in;
    logic reply;
    logic pop_rd;
    logic pop_ld;
    logic run;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic start_round;
    logic pop_done;
    logic run_done;
    logic slot_free;
  } sts_t;

endpackage

// ----- sv/rrs_ram.sv -----
// ----------------------------------------------------------------------------
// rrs_ram
// generic simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

// ----- sv/rrs_ctrl.sv -----
// ----------------------------------------------------------------------------
// rrs_ctrl
// sequencer: takes an item, then replies or pops and runs the round
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rrs_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  rrs_pkg::sts_t sts,
  output rrs_pkg::cmd_t cmd
);

  import rrs_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = sts.start_round ? ST_POP : ST_REPLY;
        end
      end
      ST_REPLY: begin
        if (sts.slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_POP: begin
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        state_nxt = sts.pop_done ? ST_RUN : ST_POP;
      end
      ST_RUN: begin
        if (sts.slot_free && sts.run_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // commands
  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.take_in = in_valid;
      end
      ST_REPLY: begin
        cmd.reply = sts.slot_free;
      end
      ST_POP: begin
        cmd.pop_rd = 1'b1;
      end
      ST_LOAD: begin
        cmd.pop_ld = 1'b1;
      end
      ST_RUN: begin
        cmd.run = sts.slot_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ----- sv/rrs_dp.sv -----
// ----------------------------------------------------------------------------
// rrs_dp
// datapath: ready ring, pointers, clock, run buffer and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rrs_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  rrs_pkg::in_item_t in_data,
  output rrs_pkg::out_item_t out_data,
  output logic              out_valid,
  input  logic              out_ready,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_wdata,
  input  rrs_pkg::cmd_t     cmd,
  output rrs_pkg::sts_t     sts
);

  import rrs_pkg::*;

  // configuration
  logic [15:0] slice_r;
  logic [2:0]  cpus_r;

  // queue and time state
  logic [QA_W-1:0]   head_r;
  logic [QA_W-1:0]   tail_r;
  logic [FILL_W-1:0] fill_r;
  logic [31:0]       now_r;

  // latched item and round bookkeeping
  in_item_t          item_r;
  logic [CPUN_W-1:0] n_r;
  logic [CPU_W-1:0]  pop_idx_r;
  logic [CPU_W-1:0]  run_idx_r;
  entry_t            run_r [MAX_CPUS];

  // result register
  out_item_t out_r;
  logic      out_valid_r;
  out_item_t out_nxt;
  logic      load_out;

  // ram ports
  logic              ram_we;
  logic [QA_W-1:0]   ram_waddr;
  entry_t            ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;

  // combinational helpers
  logic [31:0]       cc32;
  logic [31:0]       ncpu32;
  logic [31:0]       fill32;
  logic [31:0]       n32;
  logic [15:0]       slice_eff;
  logic              ring_full;
  logic              slot_free;
  entry_t            cur;
  logic [15:0]       t_run;
  logic [15:0]       left;
  logic [31:0]       end_t;
  logic              fin;
  logic [CPU_W+1:0]  idx_ext;
  logic [CPUN_W-1:0] pop_cnt;
  logic [CPUN_W-1:0] run_cnt;
  logic              push;
  logic [QA_W-1:0]   tail_inc;
  logic [QA_W-1:0]   head_inc;

  // configuration writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slice_r <= SLICE_RST;
      cpus_r  <= CPUS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TIME_SLICE: slice_r <= cfg_wdata;
        REG_CPU_COUNT:  cpus_r  <= cfg_wdata[2:0];
        default: begin
        end
      endcase
    end
  end

  // effective slice and cpu count for this round
  always_comb begin
    slice_eff = (slice_r == 16'd0) ? 16'd1 : slice_r;
    cc32      = 32'(cpus_r);
    if (cc32 == 32'd0) begin
      ncpu32 = 32'd1;
    end else if (cc32 > 32'(MAX_CPUS)) begin
      ncpu32 = 32'(MAX_CPUS);
    end else begin
      ncpu32 = cc32;
    end
    fill32 = 32'(fill_r);
    n32    = (fill32 < ncpu32) ? fill32 : ncpu32;
  end

  assign ring_full = (fill_r == FILL_W'(QUEUE_DEPTH));
  assign slot_free = !out_valid_r || out_ready;

  // ring pointer advance with wrap
  assign tail_inc = (tail_r == QA_W'(QUEUE_DEPTH - 1)) ? '0 : tail_r + 1'b1;
  assign head_inc = (head_r == QA_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;

  // slice arithmetic for the current cpu
  always_comb begin
    cur     = run_r[run_idx_r];
    t_run   = (cur.remain < slice_eff) ? cur.remain : slice_eff;
    left    = cur.remain - t_run;
    end_t   = now_r + 32'(t_run);
    fin     = (left == 16'd0);
    idx_ext = (CPU_W + 2)'(run_idx_r);
  end

  assign pop_cnt = CPUN_W'(pop_idx_r) + 1'b1;
  assign run_cnt = CPUN_W'(run_idx_r) + 1'b1;

  // status to the sequencer
  always_comb begin
    sts.start_round = (in_data.action == ACT_ROUND) && (fill_r != '0);
    sts.pop_done    = (pop_cnt == n_r);
    sts.run_done    = (run_cnt == n_r);
    sts.slot_free   = slot_free;
  end

  // ring writes: accepted adds and requeued jobs
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = tail_r;
    ram_wdata = '{id: item_r.job_id, burst: item_r.burst_time,
                  remain: item_r.burst_time};
    push      = 1'b0;
    if (cmd.reply && item_r.action == ACT_ADD && !ring_full) begin
      ram_we = 1'b1;
      push   = 1'b1;
    end else if (cmd.run && !fin) begin
      ram_we    = 1'b1;
      push      = 1'b1;
      ram_wdata = '{id: cur.id, burst: cur.burst, remain: left};
    end
  end

  rrs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.pop_rd),
    .raddr (head_r),
    .rdata (ram_rdata)
  );

  // pointers, fill count and time
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      fill_r <= '0;
      now_r  <= '0;
    end else begin
      if (cmd.pop_rd) begin
        head_r <= head_inc;
        fill_r <= fill_r - 1'b1;
      end else if (push) begin
        fill_r <= fill_r + 1'b1;
      end
      if (push) begin
        tail_r <= tail_inc;
      end
      if (cmd.run && sts.run_done) begin
        now_r <= now_r + 32'(slice_eff);
      end
    end
  end

  // item latch and round counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r       <= '0;
      pop_idx_r <= '0;
      run_idx_r <= '0;
    end else begin
      if (cmd.take_in) begin
        n_r       <= CPUN_W'(n32);
        pop_idx_r <= '0;
        run_idx_r <= '0;
      end
      if (cmd.pop_ld) begin
        pop_idx_r <= pop_idx_r + 1'b1;
      end
      if (cmd.run) begin
        run_idx_r <= run_idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      item_r <= in_data;
    end
  end

  // popped jobs land in the run buffer
  always_ff @(posedge clk) begin
    if (cmd.pop_ld) begin
      run_r[pop_idx_r] <= entry_t'(ram_rdata);
    end
  end

  // next result beat
  always_comb begin
    out_nxt  = '0;
    load_out = cmd.reply || cmd.run;
    if (cmd.run) begin
      out_nxt.kind        = KIND_SLICE;
      out_nxt.cpu_index   = idx_ext[1:0];
      out_nxt.run_job     = cur.id;
      out_nxt.slice_start = now_r;
      out_nxt.slice_end   = end_t;
      out_nxt.finished    = fin;
      out_nxt.wait_time   = fin ? (end_t - 32'(cur.burst)) : 32'd0;
      out_nxt.last        = sts.run_done;
    end else if (item_r.action == ACT_ADD) begin
      out_nxt.kind    = ring_full ? KIND_REJECT : KIND_ACCEPT;
      out_nxt.run_job = item_r.job_id;
      out_nxt.last    = 1'b1;
    end else begin
      out_nxt.kind = KIND_IDLE;
      out_nxt.last = 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_r <= out_nxt;
    end
  end

  assign out_data  = out_r;
  assign out_valid = out_valid_r;

endmodule

// ----- sv/multi_cpu_round_robin_scheduler.sv -----
// ----------------------------------------------------------------------------
// multi_cpu_round_robin_scheduler
// add or reject result: the input beat moves the sequencer to REPLY, which
// loads the result register once the output slot is free; round of n jobs:
// each pop is a registered ring read (POP, then LOAD), then RUN writes one
// slice per job, holding while stalled; an idle round replies with one beat
// reset (rst_n, synchronous): empty ring, time 0, slice 5, four cpus
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module multi_cpu_round_robin_scheduler (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rrs_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output rrs_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_wdata
);

  import rrs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer
  rrs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // queue, timing and result datapath
  rrs_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// ----- sv/rrs_chk.sv -----
// ----------------------------------------------------------------------------
// rrs_chk
// port level checks of the scheduler, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rrs_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input rrs_pkg::out_item_t out_data
);

  import rrs_pkg::*;

  logic out_stall;
  logic in_beat;
  logic single_kind;
  logic open_slice;

  // handshake and result classification
  assign out_stall   = out_valid && !out_ready;
  assign in_beat     = in_valid && in_ready;
  assign single_kind = out_data.kind inside {KIND_ACCEPT, KIND_REJECT, KIND_IDLE};
  assign open_slice  = out_valid && !out_data.finished;

  // a stalled result beat holds
  `ASSERT_NXT(a_out_hold, out_stall, out_valid && $stable(out_data), "stalled beat changed")

  // one item at a time: no input beat right after another
  `ASSERT_NXT(a_one_item, in_beat, !in_ready, "input taken on consecutive cycles")

  // add, reject and idle results are single beats
  `ASSERT_IMP(a_single_last, out_valid && single_kind, out_data.last, "single without last")

  // while taking input, any pending beat closes the previous item
  `ASSERT_IMP(a_ready_last, in_ready && out_valid, out_data.last, "input taken mid item")

  // unfinished slices carry no wait time
  `ASSERT_IMP(a_wait_zero, open_slice, out_data.wait_time == 32'd0, "wait on open slice")

endmodule

bind multi_cpu_round_robin_scheduler rrs_chk u_rrs_chk (.*);
